// ===== design/lpe_pkg.sv =====
// shared constants, register map and inter-module types of the line position estimator
`timescale 1ns / 1ps

package lpe_pkg;

    // default array geometry
    localparam int NUM_SENSORS_DEF  = 5;
    localparam int SENSOR_PITCH_DEF = 1000;
    localparam int INPUT_FIELDS     = 5;

    // sample and level scale
    localparam int SAMPLE_W    = 10;
    localparam int LEVEL_W     = 10;
    localparam int FULL_LEVEL  = 1000;
    localparam int LEVEL_STEPS = 10;
    localparam int LEVEL_CNT_W = $clog2(LEVEL_STEPS + 1);

    // output position range
    localparam int POS_W   = 12;
    localparam int POS_MAX = 2047;
    localparam int POS_MIN = -2048;

    // configuration port
    localparam int CFG_W   = 10;
    localparam int APB_DW  = 32;
    localparam int ADDR_W  = 4;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_CALIB_MIN = 2'd0;
    localparam logic [IDX_W-1:0] REG_CALIB_MAX = 2'd1;
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd2;

    localparam logic [CFG_W-1:0] CALIB_MIN_RST = 10'd0;
    localparam logic [CFG_W-1:0] CALIB_MAX_RST = 10'd256;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 10'd750;

    // what one lane hands to the merging stage
    typedef struct packed {
        logic               done;
        logic               over;
        logic [LEVEL_W-1:0] level;
    } t_lane_out;

    // what the merging stage hands back to the top level
    typedef struct packed {
        logic                    done;
        logic                    seen;
        logic                    nonneg;
        logic signed [POS_W-1:0] position;
    } t_merge_res;

endpackage

// ===== design/lpe_lane.sv =====
// one sensor lane: calibrated per-mille level with a bit-serial divider
`timescale 1ns / 1ps

module lpe_lane #(
    parameter int WSW    = 23,
    parameter int WEIGHT = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lpe_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [lpe_pkg::CFG_W-1:0]     i_calib_min,
    input  logic [lpe_pkg::CFG_W-1:0]     i_calib_max,
    input  logic [lpe_pkg::CFG_W-1:0]     i_threshold,
    output lpe_pkg::t_lane_out            o_lane,
    output logic [WSW-1:0]                o_wlevel
);

    localparam int LW = lpe_pkg::LEVEL_W;
    localparam int NW = 2 * LW;

    logic [lpe_pkg::LEVEL_CNT_W-1:0] r_cnt, n_cnt;
    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic                            r_fixed, r_fix_full;
    logic [LW-1:0]                   r_rem, r_nq;
    logic [LW-1:0]                   r_level;
    logic                            r_over;
    logic [WSW-1:0]                  r_wlevel;

    logic          w_above, w_nospan;
    logic [LW-1:0] w_d, w_span, w_level;
    logic [NW-1:0] w_num;
    logic [LW:0]   w_rem_sh, w_diff;
    logic          w_ge;

    always_comb begin
        w_above  = i_sample > i_calib_min;
        w_nospan = i_calib_max <= i_calib_min;
        w_d      = i_sample - i_calib_min;
        w_span   = i_calib_max - i_calib_min;
        w_num    = NW'(w_d) * NW'(lpe_pkg::FULL_LEVEL);
        w_rem_sh = {r_rem, r_nq[LW-1]};
        w_diff   = w_rem_sh - {1'b0, w_span};
        w_ge     = w_rem_sh >= {1'b0, w_span};
        if (r_fixed) begin
            w_level = r_fix_full ? LW'(lpe_pkg::FULL_LEVEL) : '0;
        end else begin
            w_level = r_nq;
        end
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_cnt  = lpe_pkg::LEVEL_CNT_W'(lpe_pkg::LEVEL_STEPS);
            n_busy = 1'b1;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
        end else if (r_busy) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath: load, shift-subtract steps, then level and weight stage
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_fixed    <= !w_above || w_nospan || (w_d >= w_span);
            r_fix_full <= w_above;
            r_rem      <= w_num[NW-1:LW];
            r_nq       <= w_num[LW-1:0];
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[LW-1:0] : w_rem_sh[LW-1:0];
            r_nq  <= {r_nq[LW-2:0], w_ge};
        end else if (r_busy) begin
            r_level  <= w_level;
            r_over   <= w_level > i_threshold;
            r_wlevel <= WSW'(w_level) * WSW'(WEIGHT);
        end
    end

    assign o_lane.done  = r_done;
    assign o_lane.over  = r_over;
    assign o_lane.level = r_level;
    assign o_wlevel     = r_wlevel;

endmodule

// ===== design/lpe_merge.sv =====
// merging stage: level sums, detection and the serial centroid divider
`timescale 1ns / 1ps

module lpe_merge #(
    parameter int NUM_SENSORS  = lpe_pkg::NUM_SENSORS_DEF,
    parameter int SENSOR_PITCH = lpe_pkg::SENSOR_PITCH_DEF,
    parameter int WSW          = 23
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lpe_pkg::t_lane_out    i_lane [NUM_SENSORS],
    input  logic [WSW-1:0]        i_wlevel [NUM_SENSORS],
    input  logic                  i_dir,
    output lpe_pkg::t_merge_res   o_res
);

    localparam int SPAN   = (NUM_SENSORS - 1) * SENSOR_PITCH;
    localparam int CENTRE = SPAN / 2;
    localparam int QW     = $clog2(SPAN + 1);
    localparam int LSW    = $clog2(NUM_SENSORS * lpe_pkg::FULL_LEVEL + 1);
    localparam int AW     = (WSW > LSW + QW) ? WSW : LSW + QW;
    localparam int CW     = $clog2(QW + 1);
    localparam int EW     = (QW + 2 > lpe_pkg::POS_W + 1) ? QW + 2 : lpe_pkg::POS_W + 1;

    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic           r_over;
    logic [LSW-1:0] r_lsum, r_rem;
    logic [QW-1:0]  r_nq;

    logic [LSW-1:0]         w_lsum;
    logic [WSW-1:0]         w_wsum;
    logic [AW-1:0]          w_top;
    logic                   w_over;
    logic [LSW:0]           w_rem_sh, w_diff;
    logic                   w_ge;
    logic [QW:0]            w_nq_sh;
    logic [EW-1:0]          w_qx;
    logic signed [EW-1:0]   w_centre, w_hi, w_lo, w_raw, w_sat;

    // adds over the lanes, all independent terms
    always_comb begin
        w_lsum = '0;
        w_wsum = '0;
        w_over = 1'b0;
        for (int k = 0; k < NUM_SENSORS; k++) begin
            w_lsum = w_lsum + LSW'(i_lane[k].level);
            w_wsum = w_wsum + i_wlevel[k];
            w_over = w_over | i_lane[k].over;
        end
        w_top = AW'(w_wsum) >> QW;
    end

    always_comb begin
        w_rem_sh = {r_rem, r_nq[QW-1]};
        w_diff   = w_rem_sh - {1'b0, r_lsum};
        w_ge     = w_rem_sh >= {1'b0, r_lsum};
        w_nq_sh  = {r_nq, w_ge};
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_lane[0].done) begin
            n_cnt  = CW'(QW);
            n_busy = 1'b1;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // quotient bits shift in where the low dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_lane[0].done) begin
            r_over <= w_over;
            r_lsum <= w_lsum;
            r_rem  <= w_top[LSW-1:0];
            r_nq   <= w_wsum[QW-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[LSW-1:0] : w_rem_sh[LSW-1:0];
            r_nq  <= w_nq_sh[QW-1:0];
        end
    end

    always_comb begin
        w_qx     = EW'(r_nq);
        w_centre = EW'(CENTRE);
        w_hi     = EW'(lpe_pkg::POS_MAX);
        w_lo     = EW'(lpe_pkg::POS_MIN);
        if (o_res.seen) begin
            w_raw = $signed(w_qx) - w_centre;
        end else if (i_dir) begin
            w_raw = w_centre;
        end else begin
            w_raw = -w_centre;
        end
        if (w_raw > w_hi) begin
            w_sat = w_hi;
        end else if (w_raw < w_lo) begin
            w_sat = w_lo;
        end else begin
            w_sat = w_raw;
        end
    end

    assign o_res.done     = r_done;
    assign o_res.seen     = r_over && (r_lsum != '0);
    assign o_res.nonneg   = !w_raw[EW-1];
    assign o_res.position = w_sat[lpe_pkg::POS_W-1:0];

endmodule

// ===== design/line_position_estimator_core.sv =====
// top level of the line position estimator: config registers, lanes, merge, output register
`timescale 1ns / 1ps

// a request passes the 10-step level divider in the lanes, then the QW-step centroid
// divider in the merge stage, QW being the bit count of (NUM_SENSORS-1)*SENSOR_PITCH
// one request in flight: a new one is accepted only after the previous result has been
// loaded into the output register
// reset: synchronous, active low; config returns to min 0, max 256, threshold 750 and
// the last-direction bit to 0; no clearing pass, ready the cycle after reset

module line_position_estimator_core #(
    parameter int NUM_SENSORS  = lpe_pkg::NUM_SENSORS_DEF,
    parameter int SENSOR_PITCH = lpe_pkg::SENSOR_PITCH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // apb-style config port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lpe_pkg::ADDR_W-1:0]         paddr,
    input  logic [lpe_pkg::APB_DW-1:0]         pwdata,
    output logic [lpe_pkg::APB_DW-1:0]         prdata,
    output logic                               pready,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [lpe_pkg::SAMPLE_W-1:0]       i_sensor_0,
    input  logic [lpe_pkg::SAMPLE_W-1:0]       i_sensor_1,
    input  logic [lpe_pkg::SAMPLE_W-1:0]       i_sensor_2,
    input  logic [lpe_pkg::SAMPLE_W-1:0]       i_sensor_3,
    input  logic [lpe_pkg::SAMPLE_W-1:0]       i_sensor_4,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [lpe_pkg::POS_W-1:0]   o_line_position,
    output logic                               o_line_seen,
    output logic                               o_heading_right
);

    // weighted level sum width, worst case over all lanes
    localparam int WSW = $clog2(NUM_SENSORS * (NUM_SENSORS - 1) / 2 * SENSOR_PITCH
                                * lpe_pkg::FULL_LEVEL + 1);

    // sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [lpe_pkg::CFG_W-1:0]   r_calib_min, r_calib_max, r_threshold;
    logic                        r_dir, n_dir;
    logic                        r_out_valid, n_out_valid;
    logic signed [lpe_pkg::POS_W-1:0] r_line_position;
    logic                        r_line_seen;
    logic                        r_heading_right;

    logic                         w_accept;
    logic                         w_cfg_wr;
    logic [lpe_pkg::IDX_W-1:0]    w_idx;
    logic                         w_out_free;
    logic                         w_load;
    logic [lpe_pkg::SAMPLE_W-1:0] w_sensor [lpe_pkg::INPUT_FIELDS];
    logic [lpe_pkg::SAMPLE_W-1:0] w_lane_sample [NUM_SENSORS];
    lpe_pkg::t_lane_out           w_lane [NUM_SENSORS];
    logic [WSW-1:0]               w_wlevel [NUM_SENSORS];
    logic [NUM_SENSORS-1:0]       w_lane_done;
    lpe_pkg::t_merge_res          w_mres;

    // ------------------------------------------------------------------
    // config registers, written in the access phase, read back zero-extended
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_idx    = paddr[lpe_pkg::ADDR_W-1:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_min <= lpe_pkg::CALIB_MIN_RST;
            r_calib_max <= lpe_pkg::CALIB_MAX_RST;
            r_threshold <= lpe_pkg::THRESHOLD_RST;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                lpe_pkg::REG_CALIB_MIN: r_calib_min <= pwdata[lpe_pkg::CFG_W-1:0];
                lpe_pkg::REG_CALIB_MAX: r_calib_max <= pwdata[lpe_pkg::CFG_W-1:0];
                lpe_pkg::REG_THRESHOLD: r_threshold <= pwdata[lpe_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lpe_pkg::REG_CALIB_MIN: prdata = lpe_pkg::APB_DW'(r_calib_min);
            lpe_pkg::REG_CALIB_MAX: prdata = lpe_pkg::APB_DW'(r_calib_max);
            lpe_pkg::REG_THRESHOLD: prdata = lpe_pkg::APB_DW'(r_threshold);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sensor lanes, all started by the request accept and finishing together
    // ------------------------------------------------------------------
    assign w_accept = i_in_valid && o_in_ready;

    assign w_sensor[0] = i_sensor_0;
    assign w_sensor[1] = i_sensor_1;
    assign w_sensor[2] = i_sensor_2;
    assign w_sensor[3] = i_sensor_3;
    assign w_sensor[4] = i_sensor_4;

    for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
        // lanes beyond the physical inputs see a zero reading
        if (g < lpe_pkg::INPUT_FIELDS) begin : g_in
            assign w_lane_sample[g] = w_sensor[g];
        end else begin : g_zero
            assign w_lane_sample[g] = '0;
        end

        lpe_lane #(
            .WSW    (WSW),
            .WEIGHT (g * SENSOR_PITCH)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_start     (w_accept),
            .i_sample    (w_lane_sample[g]),
            .i_calib_min (r_calib_min),
            .i_calib_max (r_calib_max),
            .i_threshold (r_threshold),
            .o_lane      (w_lane[g]),
            .o_wlevel    (w_wlevel[g])
        );

        assign w_lane_done[g] = w_lane[g].done;
    end

    // ------------------------------------------------------------------
    // merge: sums, detection, centroid divide, position and saturation
    // ------------------------------------------------------------------
    lpe_merge #(
        .NUM_SENSORS  (NUM_SENSORS),
        .SENSOR_PITCH (SENSOR_PITCH),
        .WSW          (WSW)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lane   (w_lane),
        .i_wlevel (w_wlevel),
        .i_dir    (r_dir),
        .o_res    (w_mres)
    );

    // ------------------------------------------------------------------
    // sequencer: one request in flight; the merge result stays put until
    // the output register is free, so a stalled consumer never loses it
    // ------------------------------------------------------------------
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load     = w_out_free &&
                        (((r_state == ST_BUSY) && w_mres.done) || (r_state == ST_HOLD));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_BUSY;
            end
            ST_BUSY: begin
                if (w_mres.done) n_state = w_out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // last-direction bit moves only when a line was seen
    always_comb begin
        n_dir = r_dir;
        if (w_load && w_mres.seen) n_dir = w_mres.nonneg;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dir       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dir       <= n_dir;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_line_position <= w_mres.position;
            r_line_seen     <= w_mres.seen;
            r_heading_right <= n_dir;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_line_position = r_line_position;
    assign o_line_seen     = r_line_seen;
    assign o_heading_right = r_heading_right;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // lanes share start and step count, so they finish in the same cycle
    a_lanes_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lane_done == '0) || (w_lane_done == '1))
        else $error("sensor lanes finished out of step");

    // a merge result only appears while a request is being worked on
    a_merge_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mres.done |-> (r_state == ST_BUSY))
        else $error("merge result outside of busy state");

    // with a line seen the heading bit follows the sign of the position
    a_heading_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_line_seen) |-> (r_heading_right == !r_line_position[lpe_pkg::POS_W-1]))
        else $error("heading bit disagrees with position sign");

    // the shown heading is the stored direction until the next result loads
    a_heading_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_heading_right == r_dir))
        else $error("heading output differs from stored direction");

endmodule

// ===== tb/line_position_estimator_checker.sv =====
// checker: tracks calibration writes, predicts line fixes and compares them with the results
`timescale 1ns / 1ps

module line_position_estimator_checker (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [lpe_pkg::ADDR_W-1:0]                paddr,
    input  logic [lpe_pkg::APB_DW-1:0]                pwdata,
    input  logic                                      pready,
    input  logic                                      i_in_valid,
    input  logic                                      i_in_ready,
    input  logic [lpe_pkg::SAMPLE_W-1:0]              i_sensor_0,
    input  logic [lpe_pkg::SAMPLE_W-1:0]              i_sensor_1,
    input  logic [lpe_pkg::SAMPLE_W-1:0]              i_sensor_2,
    input  logic [lpe_pkg::SAMPLE_W-1:0]              i_sensor_3,
    input  logic [lpe_pkg::SAMPLE_W-1:0]              i_sensor_4,
    input  logic                                      i_out_valid,
    input  logic                                      i_out_ready,
    input  logic signed [lpe_pkg::POS_W-1:0]          i_line_position,
    input  logic                                      i_line_seen,
    input  logic                                      i_heading_right,
    output int                                        o_fail_count,
    output int                                        o_pending
);

    localparam int CENTRE       = (lpe_pkg::NUM_SENSORS_DEF - 1) * lpe_pkg::SENSOR_PITCH_DEF / 2;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [lpe_pkg::POS_W-1:0] position;
        logic                             seen;
        logic                             heading;
    } t_line_fix;

    logic [lpe_pkg::CFG_W-1:0] cal_min     = lpe_pkg::CALIB_MIN_RST;
    logic [lpe_pkg::CFG_W-1:0] cal_max     = lpe_pkg::CALIB_MAX_RST;
    logic [lpe_pkg::CFG_W-1:0] cal_thresh  = lpe_pkg::THRESHOLD_RST;
    logic                      heading_bit = 1'b0;
    t_line_fix                 awaited_fixes[$];
    int                        fail_tally = 0;
    t_line_fix                 fresh_fix, oldest_fix, seen_fix;

    logic [lpe_pkg::INPUT_FIELDS-1:0][lpe_pkg::SAMPLE_W-1:0] reading;
    assign reading = {i_sensor_4, i_sensor_3, i_sensor_2, i_sensor_1, i_sensor_0};

    // per-mille level of one reading under the current calibration
    function automatic int unsigned sensor_level(input logic [lpe_pkg::SAMPLE_W-1:0] rd);
        int unsigned diff, span, lvl;
        if (rd <= cal_min) return 0;
        if (cal_max <= cal_min) return lpe_pkg::FULL_LEVEL;
        diff = rd - cal_min;
        span = cal_max - cal_min;
        lvl  = (diff * lpe_pkg::FULL_LEVEL) / span;
        return (lvl > lpe_pkg::FULL_LEVEL) ? lpe_pkg::FULL_LEVEL : lvl;
    endfunction

    function automatic t_line_fix estimate_fix(
        input logic [lpe_pkg::INPUT_FIELDS-1:0][lpe_pkg::SAMPLE_W-1:0] rd,
        input logic                                                    dir_in
    );
        int unsigned lvl, weighted, total;
        logic        over;
        int          pos;
        t_line_fix   fix;
        weighted = 0;
        total    = 0;
        over     = 1'b0;
        for (int i = 0; i < lpe_pkg::NUM_SENSORS_DEF; i++) begin
            lvl = (i < lpe_pkg::INPUT_FIELDS) ? sensor_level(rd[i]) : 0;
            weighted += i * lpe_pkg::SENSOR_PITCH_DEF * lvl;
            total    += lvl;
            if (lvl > cal_thresh) over = 1'b1;
        end
        fix.seen = over && (total != 0);
        if (fix.seen) begin
            pos         = int'(weighted / total) - CENTRE;
            fix.heading = (pos >= 0);
        end else begin
            pos         = dir_in ? CENTRE : -CENTRE;
            fix.heading = dir_in;
        end
        if (pos > lpe_pkg::POS_MAX) pos = lpe_pkg::POS_MAX;
        if (pos < lpe_pkg::POS_MIN) pos = lpe_pkg::POS_MIN;
        fix.position = pos[lpe_pkg::POS_W-1:0];
        return fix;
    endfunction

    task automatic note_failure(input string what, input t_line_fix want, input t_line_fix got);
        if (fail_tally < REPORT_LIMIT)
            $display("%0t %s: expected pos %0d seen %0b right %0b, got pos %0d seen %0b right %0b",
                     $time, what, want.position, want.seen, want.heading,
                     got.position, got.seen, got.heading);
        fail_tally++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cal_min     = lpe_pkg::CALIB_MIN_RST;
            cal_max     = lpe_pkg::CALIB_MAX_RST;
            cal_thresh  = lpe_pkg::THRESHOLD_RST;
            heading_bit = 1'b0;
            awaited_fixes.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[lpe_pkg::ADDR_W-1:2])
                    lpe_pkg::REG_CALIB_MIN: cal_min    = pwdata[lpe_pkg::CFG_W-1:0];
                    lpe_pkg::REG_CALIB_MAX: cal_max    = pwdata[lpe_pkg::CFG_W-1:0];
                    lpe_pkg::REG_THRESHOLD: cal_thresh = pwdata[lpe_pkg::CFG_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                fresh_fix   = estimate_fix(reading, heading_bit);
                heading_bit = fresh_fix.heading;
                awaited_fixes.push_back(fresh_fix);
            end
            if (i_out_valid && i_out_ready) begin
                seen_fix.position = i_line_position;
                seen_fix.seen     = i_line_seen;
                seen_fix.heading  = i_heading_right;
                if (awaited_fixes.size() == 0) begin
                    note_failure("result with nothing awaited", '0, seen_fix);
                end else begin
                    oldest_fix = awaited_fixes.pop_front();
                    if (seen_fix.position !== oldest_fix.position ||
                        seen_fix.seen !== oldest_fix.seen ||
                        seen_fix.heading !== oldest_fix.heading)
                        note_failure("mismatch", oldest_fix, seen_fix);
                end
            end
        end
        o_pending    <= awaited_fixes.size();
        o_fail_count <= fail_tally;
    end

endmodule

// ===== tb/line_position_estimator_core_test.sv =====
// testbench top of the line position estimator: stimulus, calibration phases and verdict
`timescale 1ns / 1ps

module line_position_estimator_core_test;

    // run shape
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 175;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES  = 60;
    localparam int LIMIT_NS       = 10_000_000;

    logic                               i_clk   = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               psel    = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite  = 1'b0;
    logic [lpe_pkg::ADDR_W-1:0]         paddr   = '0;
    logic [lpe_pkg::APB_DW-1:0]         pwdata  = '0;
    logic [lpe_pkg::APB_DW-1:0]         prdata;
    logic                               pready;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic [lpe_pkg::SAMPLE_W-1:0]       i_sensor_0 = '0;
    logic [lpe_pkg::SAMPLE_W-1:0]       i_sensor_1 = '0;
    logic [lpe_pkg::SAMPLE_W-1:0]       i_sensor_2 = '0;
    logic [lpe_pkg::SAMPLE_W-1:0]       i_sensor_3 = '0;
    logic [lpe_pkg::SAMPLE_W-1:0]       i_sensor_4 = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic signed [lpe_pkg::POS_W-1:0]   o_line_position;
    logic                               o_line_seen;
    logic                               o_heading_right;

    int fail_count;
    int pending;

    // calibration last written, used to shape realistic line profiles
    int cur_min = int'(lpe_pkg::CALIB_MIN_RST);
    int cur_max = int'(lpe_pkg::CALIB_MAX_RST);

    // pacing knobs of the stimulus and the receiver process
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    bit rx_hold_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    line_position_estimator_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sensor_0      (i_sensor_0),
        .i_sensor_1      (i_sensor_1),
        .i_sensor_2      (i_sensor_2),
        .i_sensor_3      (i_sensor_3),
        .i_sensor_4      (i_sensor_4),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_line_position (o_line_position),
        .o_line_seen     (o_line_seen),
        .o_heading_right (o_heading_right)
    );

    // watches both channels and the config port, predicts and compares
    line_position_estimator_checker fix_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_sensor_0      (i_sensor_0),
        .i_sensor_1      (i_sensor_1),
        .i_sensor_2      (i_sensor_2),
        .i_sensor_3      (i_sensor_3),
        .i_sensor_4      (i_sensor_4),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_line_position (o_line_position),
        .i_line_seen     (o_line_seen),
        .i_heading_right (o_heading_right),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // idle length: mostly none, often a few cycles, now and then a long gap
    function automatic int idle_span(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // random reading in a..b, kept inside the 10 bit sample range
    function automatic logic [lpe_pkg::SAMPLE_W-1:0] pick(input int a, input int b);
        if (b > 1023) b = 1023;
        if (a > b) a = b;
        return lpe_pkg::SAMPLE_W'($urandom_range(b, a));
    endfunction

    // offer one request and hold it until accepted, then maybe idle
    task automatic send_reading(input logic [lpe_pkg::SAMPLE_W-1:0] s0, s1, s2, s3, s4);
        int gap;
        i_in_valid <= 1'b1;
        i_sensor_0 <= s0;
        i_sensor_1 <= s1;
        i_sensor_2 <= s2;
        i_sensor_3 <= s3;
        i_sensor_4 <= s4;
        do @(posedge i_clk); while (!o_in_ready);
        gap = idle_span(tx_calm);
        // with no gap, valid stays high and the next call just changes the payload
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every predicted fix has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // setup then access cycle; psel is left high so writes can follow back to back
    task automatic write_reg(input logic [lpe_pkg::IDX_W-1:0] idx,
                             input logic [lpe_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= lpe_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // calibration only changes while the block is idle
    task automatic set_calibration(input int lo, input int hi, input int thr);
        drain_results();
        write_reg(lpe_pkg::REG_CALIB_MIN, lpe_pkg::CFG_W'(lo));
        write_reg(lpe_pkg::REG_CALIB_MAX, lpe_pkg::CFG_W'(hi));
        write_reg(lpe_pkg::REG_THRESHOLD, lpe_pkg::CFG_W'(thr));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_min = lo;
        cur_max = hi;
    endtask

    // mostly a line under one sensor with softer neighbours, plus noise, no-line and flat readings
    task automatic send_random_reading();
        logic [lpe_pkg::SAMPLE_W-1:0] rd [5];
        int kind, peak, lo, hi;
        lo   = cur_min;
        hi   = (cur_max > cur_min) ? cur_max : cur_min + 1;
        kind = $urandom_range(99);
        peak = $urandom_range(4);
        for (int i = 0; i < 5; i++) begin
            if (kind < 60) begin
                if (i == peak)
                    rd[i] = pick(lo + (hi - lo) * 3 / 4, hi + 30);
                else if (i == peak - 1 || i == peak + 1)
                    rd[i] = pick(lo, hi);
                else
                    rd[i] = pick(0, lo + (hi - lo) / 8);
            end else if (kind < 85) begin
                rd[i] = pick(0, 1023);
            end else if (kind < 95) begin
                // everything dark: exercises the held direction
                rd[i] = pick(0, lo);
            end else begin
                // flat reading across the array
                rd[i] = (i == 0) ? pick(0, 1023) : rd[0];
            end
        end
        send_reading(rd[0], rd[1], rd[2], rd[3], rd[4]);
    endtask

    // receiver: random ready pattern, calm stretches, and long hold-offs on request
    initial begin
        int run, stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(19) == 0) rx_calm = !rx_calm;
            if (rx_hold_req) begin
                // long hold-off so the block fills and pushes back on requests
                rx_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                run = $urandom_range(12, 1);
                i_out_ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                stall = idle_span(rx_calm);
                if (stall != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // safety net against a hung block
    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int lo, hi, thr;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, calibration at reset values
        send_reading(0, 0, 0, 0, 0);                  // dark array, direction still left
        send_reading(1000, 1000, 1000, 1000, 1000);   // centred line, position zero
        send_reading(0, 0, 0, 0, 0);                  // dark again, now held right
        send_reading(1023, 0, 0, 0, 0);               // full-scale code, far left
        send_reading(0, 0, 0, 0, 1023);               // far right
        send_reading(0, 200, 0, 0, 0);                // one sensor past threshold
        send_reading(0, 0, 0, 192, 0);                // level equal to threshold: no line
        send_reading(0, 0, 0, 193, 0);
        send_reading(256, 128, 0, 0, 0);              // centroid truncation
        send_reading(10'h2AA, 10'h155, 10'h2AA, 10'h155, 10'h2AA);
        send_reading(10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155);

        // narrowest span at the top of the scale, zero threshold
        set_calibration(999, 1000, 0);
        send_reading(999, 1000, 999, 1023, 999);
        send_reading(998, 999, 999, 999, 999);        // all at or below min
        send_reading(1000, 999, 999, 999, 1000);

        // no span, threshold at full level: nothing can be seen
        set_calibration(500, 500, 1000);
        send_reading(501, 500, 0, 1023, 499);

        // max below min, threshold above full level
        set_calibration(800, 100, 1023);
        send_reading(801, 900, 100, 0, 1023);

        // smallest real span at the bottom
        set_calibration(0, 1, 0);
        send_reading(1, 0, 0, 0, 0);
        send_reading(0, 0, 1, 1, 1023);

        // random phases, each under its own calibration
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin lo = 0;   hi = 256;  thr = 750;  end
                1: begin lo = 0;   hi = 1000; thr = 500;  end
                2: begin lo = 100; hi = 900;  thr = 300;  end
                3: begin lo = 0;   hi = 1;    thr = 0;    end
                4: begin lo = 999; hi = 1000; thr = 1000; end
                5: begin lo = 700; hi = 300;  thr = 200;  end
                6: begin lo = 0;   hi = 1000; thr = 1023; end
                default: begin
                    lo  = $urandom_range(999);
                    hi  = $urandom_range(1000, lo + 1);
                    thr = ($urandom_range(7) == 0) ? $urandom_range(1023, 1001)
                                                   : $urandom_range(1000);
                end
            endcase
            set_calibration(lo, hi, thr);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) tx_calm = ($urandom_range(3) == 0);
                // back-pressure episode: receiver stalls while requests keep coming
                if ((ph == 2 || ph == 5) && n == 20) begin
                    rx_hold_req = 1'b1;
                    tx_calm     = 1'b1;
                end
                send_random_reading();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/lpe_pkg.sv
design/lpe_lane.sv
design/lpe_merge.sv
design/line_position_estimator_core.sv
tb/line_position_estimator_checker.sv
tb/line_position_estimator_core_test.sv
